FILE: src/dtu_pkg.sv
// Shared constants, control structs and small lookup functions for the tuple unpacker.
package dtu_pkg;

    localparam int DIMS_W        = 4;
    localparam int POS_W         = 3;
    localparam int LVL_W         = 4;
    localparam int MAX_RESULTS   = 8;
    localparam int DEF_MAX_DIMS  = 8;
    localparam int DEF_WORD_BITS = 64;
    localparam int CAP_LOG       = 34;
    localparam int DIGIT_W       = 8;
    localparam logic [DIMS_W-1:0] DIMS_RESET = 4'd2;

    // class search width: values up to 2^34
    function automatic int search_bits(input int wb);
        return (wb > CAP_LOG) ? CAP_LOG + 1 : wb;
    endfunction

    // multiplier operand width (numerator or modular inverse)
    function automatic int mul_bits(input int wb);
        return (search_bits(wb) + 1 > wb) ? search_bits(wb) + 1 : wb;
    endfunction

    function automatic int mul_digits(input int wb);
        return (mul_bits(wb) + DIGIT_W - 1) / DIGIT_W;
    endfunction

    function automatic int class_depth(input int md);
        return (md < MAX_RESULTS) ? md : MAX_RESULTS;
    endfunction

    // i = 2^tz * odd, for i in 1..8
    function automatic logic [1:0] tz_of(input logic [LVL_W-1:0] i);
        logic [1:0] r;
        case (i)
            4'd2, 4'd6: r = 2'd1;
            4'd4:       r = 2'd2;
            4'd8:       r = 2'd3;
            default:    r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [3:0] odd_of(input logic [LVL_W-1:0] i);
        logic [3:0] r;
        case (i)
            4'd3, 4'd6: r = 4'd3;
            4'd5:       r = 4'd5;
            4'd7:       r = 4'd7;
            default:    r = 4'd1;
        endcase
        return r;
    endfunction

    // inverse of the odd factor modulo 2^64 (truncates to any smaller word)
    function automatic logic [63:0] odd_inv(input logic [LVL_W-1:0] i);
        logic [63:0] r;
        case (i)
            4'd3, 4'd6: r = 64'hAAAA_AAAA_AAAA_AAAB;
            4'd5:       r = 64'hCCCC_CCCC_CCCC_CCCD;
            4'd7:       r = 64'h6DB6_DB6D_B6DB_6DB7;
            default:    r = 64'd1;
        endcase
        return r;
    endfunction

    typedef struct packed {
        logic             load;
        logic             lvl_init;
        logic             term_init;
        logic             mul1_load;
        logic             mul_step;
        logic             mul2_load;
        logic             term_end;
        logic             decide;
        logic             lvl_end;
        logic             final_lvl;
        logic             emit;
        logic [LVL_W-1:0] k;
        logic [LVL_W-1:0] i;
        logic [POS_W-1:0] j;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic [LVL_W-1:0] m;
        logic             search_open;
        logic             term_over;
    } t_status;

endpackage

FILE: src/diagonal_tuple_unpack.sv
// Top level: inverse diagonal (generalized Cantor) tuple unpacker.
//
// Request: pulse i_start with i_packed_index while o_busy is low. With dims = m
// (capped to MAX_DIMS and 8) the block emits m results W[0]..W[m-1], each for
// one cycle with o_valid high, o_position its index and o_last on the final one.
// dims = 0 takes the request and gives nothing; dims = 1 returns the index itself.
// The user must write dims via i_cfg_we/i_cfg_data only while o_busy is low; the
// block itself does not enforce it. Reset sets 2. Each level k = m..2 bisects the
// class over up to 35 steps; each step builds the binomial term by term (k terms),
// each term one digit-serial multiply by (d+i-1) and one multiply by the inverse of
// i's odd part, 8 bits per cycle; a step ends early once a term leaves the word.
// Results cannot be held off by the receiver; o_busy falls while the last result
// is on the ports, so the next request can be taken in that same cycle.
// Reset clears the controller and the output strobe.
module diagonal_tuple_unpack #(
    parameter int MAX_DIMS  = dtu_pkg::DEF_MAX_DIMS,
    parameter int WORD_BITS = dtu_pkg::DEF_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dtu_pkg::DIMS_W-1:0] i_cfg_data,
    input  logic                       i_start,
    input  logic [WORD_BITS-1:0]       i_packed_index,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [WORD_BITS-1:0]       o_component,
    output logic [dtu_pkg::POS_W-1:0]  o_position,
    output logic                       o_last
);
    import dtu_pkg::*;

    t_cmd    cmd;
    t_status status;

    dtu_ctrl #(
        .WORD_BITS(WORD_BITS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_status(status),
        .o_cmd   (cmd),
        .o_busy  (o_busy)
    );

    dtu_dpath #(
        .MAX_DIMS (MAX_DIMS),
        .WORD_BITS(WORD_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_packed_index(i_packed_index),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_valid       (o_valid),
        .o_component   (o_component),
        .o_position    (o_position),
        .o_last        (o_last)
    );

endmodule

FILE: src/dtu_dpath.sv
// Datapath: index, class search bounds, digit-serial multiplier, class store and result registers.
module dtu_dpath #(
    parameter int MAX_DIMS  = dtu_pkg::DEF_MAX_DIMS,
    parameter int WORD_BITS = dtu_pkg::DEF_WORD_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dtu_pkg::DIMS_W-1:0] i_cfg_data,
    input  logic [WORD_BITS-1:0]       i_packed_index,
    input  dtu_pkg::t_cmd              i_cmd,
    output dtu_pkg::t_status           o_status,
    output logic                       o_valid,
    output logic [WORD_BITS-1:0]       o_component,
    output logic [dtu_pkg::POS_W-1:0]  o_position,
    output logic                       o_last
);
    import dtu_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int DW   = search_bits(WORD_BITS);
    localparam int NW   = DW + 1;
    localparam int MB   = mul_bits(WORD_BITS);
    localparam int PW   = W + MB;
    localparam int NCLS = class_depth(MAX_DIMS);
    localparam int CW   = (NCLS > 1) ? $clog2(NCLS) : 1;
    localparam logic [DW:0] CAP_D = (DW+1)'(1) << CAP_LOG;

    logic [DIMS_W-1:0] r_dims;
    logic [W-1:0]      r_alpha;
    logic [DW-1:0]     r_lo, r_hi, r_mid;
    logic [W-1:0]      r_base;
    logic [W-1:0]      r_r;
    logic              r_over;
    logic [PW-1:0]     r_prod, r_ma;
    logic [MB-1:0]     r_mb;
    logic [W-1:0]      r_cls [NCLS];
    logic [W-1:0]      r_prev;

    logic [DW:0]          span;
    logic [DW-1:0]        mid;
    logic [NW-1:0]        num;
    logic [PW+DIGIT_W-1:0] pp;
    logic [PW-1:0]        sh;
    logic                 term_over;
    logic                 over_cap;
    logic [W-1:0]         cls_j;
    logic [LVL_W-1:0]     km1;
    logic [63:0]          inv;

    assign span      = {1'b0, r_hi} - {1'b0, r_lo} + (DW+1)'(1);
    assign mid       = r_lo + span[DW:1];
    assign num       = {1'b0, r_mid} + NW'(i_cmd.i) - NW'(1);
    assign pp        = {{DIGIT_W{1'b0}}, r_ma} * {{PW{1'b0}}, r_mb[DIGIT_W-1:0]};
    assign sh        = r_prod >> tz_of(i_cmd.i);
    assign term_over = sh[PW-1:W] >= MB'(odd_of(i_cmd.i));
    assign over_cap  = (r_alpha >> CAP_LOG) != '0;
    assign cls_j     = r_cls[i_cmd.j[CW-1:0]];
    assign km1       = i_cmd.k - LVL_W'(1);
    assign inv       = odd_inv(i_cmd.i);

    assign o_status.m           = (LVL_W'(r_dims) > LVL_W'(NCLS)) ? LVL_W'(NCLS)
                                                                  : LVL_W'(r_dims);
    assign o_status.search_open = r_lo < r_hi;
    assign o_status.term_over   = term_over;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= DIMS_RESET;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) r_dims <= i_cfg_data;
            o_valid <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_alpha <= i_packed_index;
        if (i_cmd.lvl_init) begin
            r_lo   <= '0;
            r_hi   <= over_cap ? CAP_D[DW-1:0] : r_alpha[DW-1:0];
            r_base <= '0;
        end
        if (i_cmd.term_init) begin
            r_mid  <= mid;
            r_r    <= W'(1);
            r_over <= 1'b0;
        end
        if (i_cmd.mul1_load) begin
            r_ma   <= PW'(r_r);
            r_mb   <= MB'(num);
            r_prod <= '0;
        end
        if (i_cmd.mul_step) begin
            r_prod <= r_prod + pp[PW-1:0];
            r_ma   <= r_ma << DIGIT_W;
            r_mb   <= r_mb >> DIGIT_W;
        end
        // exact divide: drop the power of two, then multiply by the odd inverse
        if (i_cmd.mul2_load) begin
            r_ma   <= PW'(sh[W-1:0]);
            r_mb   <= MB'(inv[W-1:0]);
            r_prod <= '0;
            r_over <= term_over;
        end
        if (i_cmd.term_end) r_r <= r_prod[W-1:0];
        if (i_cmd.decide) begin
            if (!r_over && r_r <= r_alpha) begin
                r_lo   <= r_mid;
                r_base <= r_r;
            end else begin
                r_hi <= r_mid - DW'(1);
            end
        end
        if (i_cmd.lvl_end) begin
            r_cls[km1[CW-1:0]] <= W'(r_lo);
            r_alpha            <= r_alpha - r_base;
        end
        if (i_cmd.final_lvl) r_cls[0] <= r_alpha;
        if (i_cmd.emit) begin
            o_component <= (i_cmd.j == '0) ? cls_j : cls_j - r_prev;
            o_position  <= i_cmd.j;
            o_last      <= i_cmd.last;
            r_prev      <= cls_j;
        end
    end

endmodule

FILE: src/dtu_ctrl.sv
// Controller: sequences levels, bisection steps, binomial terms, multiplier digits and output.
module dtu_ctrl #(
    parameter int WORD_BITS = dtu_pkg::DEF_WORD_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  dtu_pkg::t_status i_status,
    output dtu_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import dtu_pkg::*;

    localparam int ND  = mul_digits(WORD_BITS);
    localparam int DGW = (ND > 1) ? $clog2(ND) : 1;

    typedef enum logic [13:0] {
        S_IDLE      = 14'b00000000000001,
        S_LVL_INIT  = 14'b00000000000010,
        S_SRCH_CHK  = 14'b00000000000100,
        S_TERM_INIT = 14'b00000000001000,
        S_MUL1_LOAD = 14'b00000000010000,
        S_MUL1      = 14'b00000000100000,
        S_MUL2_LOAD = 14'b00000001000000,
        S_MUL2      = 14'b00000010000000,
        S_TERM_END  = 14'b00000100000000,
        S_DECIDE    = 14'b00001000000000,
        S_LVL_END   = 14'b00010000000000,
        S_FINAL     = 14'b00100000000000,
        S_EMIT      = 14'b01000000000000,
        S_SPARE     = 14'b10000000000000
    } t_state;

    t_state           r_state, n_state;
    logic [LVL_W-1:0] r_k, n_k, r_i, n_i;
    logic [POS_W-1:0] r_j, n_j;
    logic [DGW-1:0]   r_dig, n_dig;
    logic             accept;
    logic             last;
    logic             dig_end;

    assign accept  = (r_state == S_IDLE) && i_start;
    assign last    = {1'b0, r_j} == (i_status.m - LVL_W'(1));
    assign dig_end = r_dig == DGW'(ND - 1);
    assign o_busy  = r_state != S_IDLE;

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_dig   = r_dig;
        case (r_state)
            S_IDLE: begin
                if (i_start && i_status.m != '0) begin
                    n_k     = i_status.m;
                    n_state = (i_status.m == LVL_W'(1)) ? S_FINAL : S_LVL_INIT;
                end
            end
            S_LVL_INIT: n_state = S_SRCH_CHK;
            S_SRCH_CHK: n_state = i_status.search_open ? S_TERM_INIT : S_LVL_END;
            S_TERM_INIT: begin
                n_i     = LVL_W'(1);
                n_state = S_MUL1_LOAD;
            end
            S_MUL1_LOAD: begin
                n_dig   = '0;
                n_state = S_MUL1;
            end
            S_MUL1: begin
                n_dig = r_dig + DGW'(1);
                if (dig_end) n_state = S_MUL2_LOAD;
            end
            S_MUL2_LOAD: begin
                n_dig   = '0;
                n_state = i_status.term_over ? S_DECIDE : S_MUL2;
            end
            S_MUL2: begin
                n_dig = r_dig + DGW'(1);
                if (dig_end) n_state = S_TERM_END;
            end
            S_TERM_END: begin
                if (r_i == r_k) begin
                    n_state = S_DECIDE;
                end else begin
                    n_i     = r_i + LVL_W'(1);
                    n_state = S_MUL1_LOAD;
                end
            end
            S_DECIDE: n_state = S_SRCH_CHK;
            S_LVL_END: begin
                if (r_k == LVL_W'(2)) begin
                    n_state = S_FINAL;
                end else begin
                    n_k     = r_k - LVL_W'(1);
                    n_state = S_LVL_INIT;
                end
            end
            S_FINAL: begin
                n_j     = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (last) n_state = S_IDLE;
                else      n_j     = r_j + POS_W'(1);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_dig   <= '0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_i     <= n_i;
            r_j     <= n_j;
            r_dig   <= n_dig;
        end
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.load      = accept;
        o_cmd.lvl_init  = r_state == S_LVL_INIT;
        o_cmd.term_init = r_state == S_TERM_INIT;
        o_cmd.mul1_load = r_state == S_MUL1_LOAD;
        o_cmd.mul_step  = (r_state == S_MUL1) || (r_state == S_MUL2);
        o_cmd.mul2_load = r_state == S_MUL2_LOAD;
        o_cmd.term_end  = r_state == S_TERM_END;
        o_cmd.decide    = r_state == S_DECIDE;
        o_cmd.lvl_end   = r_state == S_LVL_END;
        o_cmd.final_lvl = r_state == S_FINAL;
        o_cmd.emit      = r_state == S_EMIT;
        o_cmd.k         = r_k;
        o_cmd.i         = r_i;
        o_cmd.j         = r_j;
        o_cmd.last      = last;
    end

endmodule

FILE: test/diagonal_tuple_unpack_check.sv
// Checker for the tuple unpacker: predicts each component list and compares results.
module diagonal_tuple_unpack_check (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [dtu_pkg::DIMS_W-1:0] i_cfg_data,
    input  logic                       i_start,
    input  logic                       i_busy,
    input  logic [63:0]                i_packed_index,
    input  logic                       i_valid,
    input  logic [63:0]                i_component,
    input  logic [dtu_pkg::POS_W-1:0]  i_position,
    input  logic                       i_last,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_requests,
    output int                         o_components
);
    import dtu_pkg::*;

    localparam logic [63:0] WORD_ALL = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SEARCH_TOP = 64'd1 << CAP_LOG;

    typedef struct {
        logic [63:0]      comp;
        logic [POS_W-1:0] pos;
        logic             last;
    } t_component;

    t_component tuple_q[$];
    logic [DIMS_W-1:0] dims_reg;

    function automatic logic [63:0] gcd64(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] t;
        while (b != 0) begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    // C(d+k-1, k); over set when it leaves the word
    function automatic logic [63:0] simplex_count(input logic [63:0] d, input int k,
                                                  output bit over);
        logic [63:0] r, num, den, g;
        r = 1;
        over = 0;
        for (int i = 1; i <= k; i++) begin
            num = d + i - 1;
            den = i;
            g = gcd64(r, den);
            if (g == 0) g = 1;
            r = r / g;
            den = den / g;
            num = num / den;
            if (num != 0 && r > WORD_ALL / num) begin
                over = 1;
                return WORD_ALL;
            end
            r = r * num;
        end
        return r;
    endfunction

    function automatic logic [63:0] class_of(input logic [63:0] alpha, input int k);
        logic [63:0] lo, hi, mid, b;
        bit over;
        lo = 0;
        hi = (alpha < SEARCH_TOP) ? alpha : SEARCH_TOP;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            b = simplex_count(mid, k, over);
            if (!over && b <= alpha) lo = mid;
            else hi = mid - 1;
        end
        return lo;
    endfunction

    task automatic predict_tuple(input logic [63:0] index);
        logic [63:0] cls [MAX_RESULTS];
        logic [63:0] alpha;
        t_component c;
        int m;
        bit over;
        m = dims_reg;
        alpha = index;
        if (m > DEF_MAX_DIMS) m = DEF_MAX_DIMS;
        if (m > MAX_RESULTS) m = MAX_RESULTS;
        for (int k = m; k >= 2; k--) begin
            cls[k-1] = class_of(alpha, k);
            alpha = alpha - simplex_count(cls[k-1], k, over);
        end
        cls[0] = alpha;
        for (int j = 0; j < m; j++) begin
            c.comp = (j == 0) ? cls[0] : cls[j] - cls[j-1];
            c.pos  = j[POS_W-1:0];
            c.last = (j == m - 1);
            tuple_q.push_back(c);
        end
    endtask

    initial begin
        o_errors = 0;
        o_requests = 0;
        o_components = 0;
        dims_reg = DIMS_RESET;
    end

    assign o_pending = tuple_q.size();

    always @(posedge i_clk) begin
        t_component e;
        if (!i_rst_n) begin
            dims_reg = DIMS_RESET;
            tuple_q.delete();
        end else begin
            if (i_valid) begin
                o_components++;
                if (tuple_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result comp=%h pos=%0d last=%0b",
                             $time, i_component, i_position, i_last);
                end else begin
                    e = tuple_q.pop_front();
                    if (i_component !== e.comp || i_position !== e.pos
                        || i_last !== e.last) begin
                        o_errors++;
                        $display("%0t: mismatch expected comp=%h pos=%0d last=%0b, got comp=%h pos=%0d last=%0b",
                                 $time, e.comp, e.pos, e.last,
                                 i_component, i_position, i_last);
                    end
                end
            end
            if (i_start && !i_busy) begin
                o_requests++;
                predict_tuple(i_packed_index);
            end
            if (i_cfg_we) dims_reg = i_cfg_data;
        end
    end
endmodule

FILE: test/diagonal_tuple_unpack_test.sv
// Testbench top: drives index requests and dims settings, reports the verdict.
module diagonal_tuple_unpack_test;
    import dtu_pkg::*;

    localparam longint CYCLE_LIMIT = 20_000_000;

    logic              i_clk, i_rst_n, i_cfg_we, i_start;
    logic [DIMS_W-1:0] i_cfg_data;
    logic [63:0]       i_packed_index;
    logic              o_busy, o_valid, o_last;
    logic [63:0]       o_component;
    logic [POS_W-1:0]  o_position;
    int                errors, pending, requests, components;
    longint            cycles;
    bit                no_gaps;

    diagonal_tuple_unpack dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_start(i_start), .i_packed_index(i_packed_index), .o_busy(o_busy),
        .o_valid(o_valid), .o_component(o_component), .o_position(o_position),
        .o_last(o_last)
    );

    diagonal_tuple_unpack_check check (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_start(i_start), .i_busy(o_busy), .i_packed_index(i_packed_index),
        .i_valid(o_valid), .i_component(o_component), .i_position(o_position),
        .i_last(o_last), .o_errors(errors), .o_pending(pending),
        .o_requests(requests), .o_components(components)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    initial cycles = 0;
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("diagonal_tuple_unpack test failed");
            $finish;
        end
    end

    // start stays high across back-to-back requests
    task automatic send_index(input logic [63:0] index);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_start <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1;
        i_packed_index <= index;
        do @(posedge i_clk); while (o_busy);
    endtask

    // drain outstanding work; dims = 0 requests leave nothing in the queue
    task automatic drain;
        i_start <= 0;
        repeat (4) @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_dims(input logic [DIMS_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    function automatic logic [63:0] rand_index;
        logic [63:0] v;
        int w;
        v = {$urandom, $urandom};
        w = $urandom_range(0, 64);
        if (w < 64) v = v & ((64'd1 << w) - 1);
        return v;
    endfunction

    function automatic logic [DIMS_W-1:0] rand_dims;
        int r;
        r = $urandom_range(0, 19);
        if (r < 6) return DIMS_W'(2);
        if (r < 10) return DIMS_W'(3);
        if (r < 12) return DIMS_W'(1);
        if (r < 14) return DIMS_W'(4);
        if (r == 14) return DIMS_W'(0);
        if (r == 15) return DIMS_W'($urandom_range(9, 15));
        if (r < 18) return DIMS_W'($urandom_range(5, 6));
        return DIMS_W'($urandom_range(7, 8));
    endfunction

    initial begin
        int n;
        i_rst_n = 0;
        i_cfg_we = 0;
        i_cfg_data = 0;
        i_start = 0;
        i_packed_index = 0;
        no_gaps = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // reset dims: small values, triangular edges, full word
        send_index(0);
        send_index(1);
        send_index(2);
        send_index(3);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        send_index(64'h8000_0000_0000_0000);
        send_index(64'h3_FFFF_FFFF);
        // eight levels: binomials overflow the word
        set_dims(4'd8);
        send_index(0);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        send_index(64'h8000_0000_0000_0000);
        send_index(12345);
        set_dims(4'd1);
        send_index(0);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        set_dims(4'd0);
        send_index(5);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        set_dims(4'd15);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        send_index(100);
        set_dims(4'd3);
        send_index(64'hFFFF_FFFF_FFFF_FFFF);
        send_index(64'h5555_5555_5555_5555);

        n = 0;
        while (n < 220) begin
            set_dims(rand_dims());
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(6, 14)) begin
                send_index(rand_index());
                n++;
            end
        end
        drain();
        repeat (100) @(posedge i_clk);

        $display("Unpacked %0d indices into %0d components over dims 0..15,",
                 requests, components);
        $display("including full-width indices and overflowing binomials.");
        if (errors == 0 && pending == 0)
            $display("diagonal_tuple_unpack test passed");
        else
            $display("diagonal_tuple_unpack test failed");
        $finish;
    end
endmodule

FILE: files.f
src/dtu_pkg.sv
src/dtu_dpath.sv
src/dtu_ctrl.sv
src/diagonal_tuple_unpack.sv
test/diagonal_tuple_unpack_check.sv
test/diagonal_tuple_unpack_test.sv
